// ===== rtl/console_line_editor_macros.svh =====
// Assertion macros for the console line editor checker.
// Expects clk and rst_n in scope at the point of use.
`ifndef CONSOLE_LINE_EDITOR_MACROS_SVH
`define CONSOLE_LINE_EDITOR_MACROS_SVH

// Same-cycle implication
`define CLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define CLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cle_pkg.sv =====
// Shared types and constants of the console line editor.
// No dependencies.
package cle_pkg;

  localparam int CLE_BUF_DEPTH = 128;
  localparam int CLE_Q_DEPTH   = 4;

  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_DEL   = 8'h7f;
  localparam logic [7:0] KEY_CR    = 8'h0d;
  localparam logic [7:0] KEY_LF    = 8'h0a;
  localparam logic [7:0] KEY_EOF   = 8'h04;
  localparam logic [7:0] KEY_SPACE = 8'h20;

  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [1:0] RS_DATA  = 2'd0;
  localparam logic [1:0] RS_NL    = 2'd1;
  localparam logic [1:0] RS_EOF   = 2'd2;
  localparam logic [1:0] RS_EMPTY = 2'd3;

  typedef struct packed {
    logic       action;
    logic [7:0] key_byte;
    logic       read_started;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic [1:0] read_status;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_CHAR = 2'd0,
    OP_BS   = 2'd1,
    OP_READ = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic       started;
  } cmd_t;

  // queue to back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

// ===== rtl/cle_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/cle_fifo.sv =====
// Short command queue between the front and back ends.
// Depends on cle_pkg.
module cle_fifo
  import cle_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  output logic    full,
  input  logic    pop,
  output q_head_t head
);

  localparam int QAW = $clog2(CLE_Q_DEPTH);
  localparam logic [QAW:0] QFULL = (QAW+1)'(CLE_Q_DEPTH);

  cmd_t           slot_r [CLE_Q_DEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           do_push, do_pop;

  assign full    = (count_r == QFULL);
  assign do_push = push && !full;
  assign do_pop  = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(CLE_Q_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(CLE_Q_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.cmd   = slot_r[rd_ptr_r];

endmodule

// ===== rtl/cle_front.sv =====
// Front end: accepts input beats, classifies them into commands.
// Depends on cle_pkg; feeds cle_fifo.
module cle_front
  import cle_pkg::*;
(
  input  in_item_t in_data,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     q_full,
  output logic     push,
  output cmd_t     push_cmd
);

  logic is_bs;
  logic is_null;

  assign is_bs   = (in_data.key_byte == KEY_BS) || (in_data.key_byte == KEY_DEL);
  assign is_null = (in_data.action == ACT_KEY) && (in_data.key_byte == 8'h00);

  always_comb begin
    push_cmd.started = in_data.read_started;
    push_cmd.ch      = (in_data.key_byte == KEY_CR) ? KEY_LF : in_data.key_byte;
    if (in_data.action == ACT_READ) begin
      push_cmd.op = OP_READ;
    end else if (is_bs) begin
      push_cmd.op = OP_BS;
    end else begin
      push_cmd.op = OP_CHAR;
    end
  end

  // null keys are taken and dropped
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full && !is_null;

endmodule

// ===== rtl/cle_back.sv =====
// Back end: executes commands against the line indices and line store.
// Depends on cle_pkg, cle_ram; drives the result output register.
module cle_back
  import cle_pkg::*;
#(
  parameter int BUF_DEPTH = CLE_BUF_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IW = $clog2(2*BUF_DEPTH);
  localparam int AW = $clog2(BUF_DEPTH);
  localparam logic [IW-1:0] SPAN_I   = IW'(2*BUF_DEPTH);
  localparam logic [IW-1:0] SPAN_M1  = IW'(2*BUF_DEPTH-1);
  localparam logic [IW-1:0] DEPTH_I  = IW'(BUF_DEPTH);
  localparam logic [IW-1:0] DEPTH_M1 = IW'(BUF_DEPTH-1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RD   = 3'b010,
    S_BS   = 3'b100
  } state_t;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
    return (i == SPAN_M1) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
    return (i == '0) ? SPAN_M1 : i - 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dist(input logic [IW-1:0] hi,
                                             input logic [IW-1:0] lo);
    return (hi >= lo) ? hi - lo : hi - lo + SPAN_I;
  endfunction

  function automatic logic [AW-1:0] idx_addr(input logic [IW-1:0] i);
    logic [IW-1:0] a;
    a = (i >= DEPTH_I) ? i - DEPTH_I : i;
    return a[AW-1:0];
  endfunction

  state_t          state_r, state_nxt;
  logic            bs_cnt_r, bs_cnt_nxt;
  logic            started_r, started_nxt;
  logic [IW-1:0]   read_r, read_nxt;
  logic [IW-1:0]   commit_r, commit_nxt;
  logic [IW-1:0]   edit_r, edit_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;
  logic            out_free;
  logic            ram_we, ram_re;
  logic [7:0]      ram_rdata;
  logic [IW-1:0]   fill;

  assign out_free = !out_valid_r || out_ready;
  assign fill     = idx_dist(edit_r, read_r);

  cle_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(idx_addr(edit_r)),
    .wdata(head.cmd.ch),
    .re   (ram_re),
    .raddr(idx_addr(read_r)),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    bs_cnt_nxt    = bs_cnt_r;
    started_nxt   = started_r;
    read_nxt      = read_r;
    commit_nxt    = commit_r;
    edit_nxt      = edit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pop           = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (head.valid && out_free) begin
          pop = 1'b1;
          unique case (head.cmd.op)
            OP_BS: begin
              if (edit_r != commit_r) begin
                edit_nxt      = idx_dec(edit_r);
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{KIND_ECHO, KEY_BS, RS_DATA, 1'b0};
                bs_cnt_nxt    = 1'b0;
                state_nxt     = S_BS;
              end
            end
            OP_CHAR: begin
              if (fill < DEPTH_I) begin
                ram_we        = 1'b1;
                edit_nxt      = idx_inc(edit_r);
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{KIND_ECHO, head.cmd.ch, RS_DATA, 1'b1};
                if (head.cmd.ch == KEY_LF || head.cmd.ch == KEY_EOF ||
                    fill == DEPTH_M1) begin
                  commit_nxt = idx_inc(edit_r);
                end
              end
            end
            OP_READ: begin
              if (read_r == commit_r) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{KIND_READ, 8'h00, RS_EMPTY, 1'b1};
              end else begin
                ram_re      = 1'b1;
                started_nxt = head.cmd.started;
                state_nxt   = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (ram_rdata == KEY_EOF) begin
            if (!started_r) begin
              read_nxt = idx_inc(read_r);
            end
            out_data_nxt = '{KIND_READ, 8'h00, RS_EOF, 1'b1};
          end else begin
            read_nxt     = idx_inc(read_r);
            out_data_nxt = '{KIND_READ, ram_rdata,
                             (ram_rdata == KEY_LF) ? RS_NL : RS_DATA, 1'b1};
          end
        end
      end
      S_BS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (!bs_cnt_r) begin
            out_data_nxt = '{KIND_ECHO, KEY_SPACE, RS_DATA, 1'b0};
            bs_cnt_nxt   = 1'b1;
          end else begin
            out_data_nxt = '{KIND_ECHO, KEY_BS, RS_DATA, 1'b1};
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bs_cnt_r    <= 1'b0;
      started_r   <= 1'b0;
      read_r      <= '0;
      commit_r    <= '0;
      edit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bs_cnt_r    <= bs_cnt_nxt;
      started_r   <= started_nxt;
      read_r      <= read_nxt;
      commit_r    <= commit_nxt;
      edit_r      <= edit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/console_line_editor.sv =====
// Top level of the console line editor: front end, command queue, back end.
// Depends on cle_pkg, cle_front, cle_fifo, cle_back.
//
// Canonical console input: key beats edit a line held in a BUF_DEPTH-byte
// ring store and produce echo beats; read beats take at most one committed
// byte each. Input beats are classified by the front end and queued (four
// entries), so the input side keeps taking beats while the back end works,
// until the queue is full. In the back end a key is written and echoed from
// the idle state, a backspace emits three echo beats through the single
// output register, and a read first reads the store and then forms the answer,
// or answers from the idle state when nothing is committed; a zero key costs
// only its input beat. Results come out at most one per cycle. The line store
// is not cleared at reset; only committed bytes are ever read, and those were always written first.
module console_line_editor
  import cle_pkg::*;
#(
  parameter int BUF_DEPTH = CLE_BUF_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic    q_full;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  q_head_t head;

  cle_front u_front (
    .in_data (in_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .q_full  (q_full),
    .push    (push),
    .push_cmd(push_cmd)
  );

  cle_fifo u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .full    (q_full),
    .pop     (pop),
    .head    (head)
  );

  cle_back #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ===== rtl/cle_checker.sv =====
// Port-level checker for the console line editor, bound to the top level.
// Depends on cle_pkg and console_line_editor_macros.svh.
`include "console_line_editor_macros.svh"

module cle_checker
  import cle_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `CLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat dropped or changed while stalled")
  `CLE_ASSERT_NOW(a_read_last, out_valid && out_data.kind == KIND_READ, out_data.last, "read answer not marked last")
  `CLE_ASSERT_NOW(a_echo_status, out_valid && out_data.kind == KIND_ECHO, out_data.read_status == RS_DATA, "echo beat with read status")
  `CLE_ASSERT_NOW(a_nodata_zero, out_valid && (out_data.read_status == RS_EOF || out_data.read_status == RS_EMPTY), out_data.out_byte == 8'h00, "eof or empty answer carries a byte")

endmodule

bind console_line_editor cle_checker u_cle_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking bench for console_line_editor: key and read beats against a
// line-discipline predictor kept in a small scoreboard class.
// Depends on cle_pkg and the console_line_editor RTL.
module testbench;
  import cle_pkg::*;

  localparam int DEPTH        = CLE_BUF_DEPTH;
  localparam int SPAN         = 2 * CLE_BUF_DEPTH;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_ITEMS   = 96;
  localparam int FLOOD_KEYS   = 12;
  localparam logic [7:0] KEY_NUL = 8'h00;

  class cooked_line_board;
    logic [7:0] line_bytes [DEPTH];
    int read_pos;
    int commit_pos;
    int edit_pos;
    out_item_t pending_answers [$];
    int bad_count;

    function new();
      read_pos   = 0;
      commit_pos = 0;
      edit_pos   = 0;
      bad_count  = 0;
    endfunction

    function int span_dist(int hi, int lo);
      return (hi + SPAN - lo) % SPAN;
    endfunction

    function int committed_bytes();
      return span_dist(commit_pos, read_pos);
    endfunction

    function void expect_beat(logic kind, logic [7:0] ch, logic [1:0] st, logic fin);
      out_item_t r;
      r.kind        = kind;
      r.out_byte    = ch;
      r.read_status = st;
      r.last        = fin;
      pending_answers.push_back(r);
    endfunction

    // returns number of result beats this input causes
    function int accept_beat(in_item_t b);
      logic [7:0] c;
      if (b.action == ACT_KEY) begin
        if (b.key_byte == KEY_BS || b.key_byte == KEY_DEL) begin
          if (edit_pos == commit_pos) return 0;
          edit_pos = (edit_pos + SPAN - 1) % SPAN;
          expect_beat(KIND_ECHO, KEY_BS, RS_DATA, 1'b0);
          expect_beat(KIND_ECHO, KEY_SPACE, RS_DATA, 1'b0);
          expect_beat(KIND_ECHO, KEY_BS, RS_DATA, 1'b1);
          return 3;
        end
        if (b.key_byte == KEY_NUL || span_dist(edit_pos, read_pos) >= DEPTH) return 0;
        c = (b.key_byte == KEY_CR) ? KEY_LF : b.key_byte;
        expect_beat(KIND_ECHO, c, RS_DATA, 1'b1);
        line_bytes[edit_pos % DEPTH] = c;
        edit_pos = (edit_pos + 1) % SPAN;
        if (c == KEY_LF || c == KEY_EOF || span_dist(edit_pos, read_pos) == DEPTH)
          commit_pos = edit_pos;
        return 1;
      end
      if (read_pos == commit_pos) begin
        expect_beat(KIND_READ, 8'h00, RS_EMPTY, 1'b1);
        return 1;
      end
      c = line_bytes[read_pos % DEPTH];
      if (c == KEY_EOF) begin
        if (!b.read_started) read_pos = (read_pos + 1) % SPAN;
        expect_beat(KIND_READ, 8'h00, RS_EOF, 1'b1);
      end else begin
        read_pos = (read_pos + 1) % SPAN;
        expect_beat(KIND_READ, c, (c == KEY_LF) ? RS_NL : RS_DATA, 1'b1);
      end
      return 1;
    endfunction

    function void compare_answer(out_item_t got);
      out_item_t want;
      if (pending_answers.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected result beat: kind=%0d byte=%02h status=%0d last=%0d",
                   got.kind, got.out_byte, got.read_status, got.last);
        return;
      end
      want = pending_answers.pop_front();
      if (got !== want) begin
        bad_count++;
        if (bad_count <= 10)
          $display("result mismatch: exp kind=%0d byte=%02h status=%0d last=%0d, %s",
                   want.kind, want.out_byte, want.read_status, want.last,
                   $sformatf("got kind=%0d byte=%02h status=%0d last=%0d",
                             got.kind, got.out_byte, got.read_status, got.last));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  cooked_line_board board;
  int tx_idle_pct;
  int rx_idle_pct;
  logic rx_hold;
  logic hold_start;
  int cycle_count;
  int answered_items;

  console_line_editor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    rx_hold     = 1'b0;
    hold_start  = 1'b0;
    cycle_count = 0;
    rx_idle_pct = 67;
    board       = new();
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) board.compare_answer(out_data);
    out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  // long receiver stall so the command queue fills and in_ready drops
  initial begin
    @(posedge hold_start);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic send_beat(input logic act, input logic [7:0] key, input logic started);
    in_item_t b;
    b.action       = act;
    b.key_byte     = key;
    b.read_started = started;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    if (board.accept_beat(b) > 0) answered_items++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic send_key(input logic [7:0] key);
    send_beat(ACT_KEY, key, 1'($urandom_range(1)));
  endtask

  task automatic send_read(input logic started);
    send_beat(ACT_READ, 8'($urandom_range(255)), started);
  endtask

  task automatic read_out(input int extra);
    repeat (board.committed_bytes() + extra) send_read(1'($urandom_range(1)));
  endtask

  function automatic logic [7:0] plain_byte();
    if ($urandom_range(3) == 0) return 8'($urandom_range(8'h80, 8'hff));
    return 8'($urandom_range(8'h21, 8'h7e));
  endfunction

  initial begin
    int r;
    int k;
    int base;
    bit flooded;
    answered_items = 0;
    flooded        = 1'b0;
    tx_idle_pct    = 7;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_read(1'b0);
    send_key(KEY_BS);
    send_key(KEY_DEL);
    send_key(KEY_NUL);
    send_key(8'h61);
    send_key(8'hff);
    send_key(8'h80);
    send_key(8'h01);
    send_key(KEY_BS);
    send_key(KEY_DEL);
    send_key(KEY_CR);
    send_read(1'b1);
    send_read(1'b0);
    send_read(1'b1);
    send_read(1'b1);
    send_key(8'h78);
    send_key(KEY_EOF);
    send_read(1'b0);
    send_read(1'b1);
    send_read(1'b0);
    send_read(1'b0);
    send_key(KEY_BS);
    send_key(KEY_LF);
    send_read(1'b0);

    base = answered_items;
    while (answered_items - base < RAND_ITEMS) begin
      k = answered_items - base;
      if (k < 32) begin
        tx_idle_pct = 7;
        rx_idle_pct <= 67;
      end else if (k < 64) begin
        tx_idle_pct = 67;
        rx_idle_pct <= 7;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end

      if (!flooded && k >= 15) begin
        hold_start <= 1'b1;
        repeat (FLOOD_KEYS) send_key(plain_byte());
        send_key(KEY_BS);
        read_out(2);
        flooded = 1'b1;
      end

      r = $urandom_range(99);
      if (r < 55) begin
        repeat ($urandom_range(1, 12)) begin
          r = $urandom_range(99);
          if (r < 85) send_key(plain_byte());
          else if (r < 93) send_key(r[0] ? KEY_BS : KEY_DEL);
          else if (r < 97) send_key(8'($urandom_range(255)));
          else send_key(KEY_NUL);
        end
        r = $urandom_range(2);
        send_key(r == 0 ? KEY_LF : (r == 1 ? KEY_CR : KEY_EOF));
        read_out($urandom_range(2));
      end else if (r < 80) begin
        repeat ($urandom_range(1, 4)) send_read(1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(1, 5)) begin
          if ($urandom_range(1)) send_key(8'($urandom_range(255)));
          else send_read(1'($urandom_range(1)));
        end
      end
    end

    in_valid <= 1'b0;
    rx_idle_pct <= 0;
    while (board.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.bad_count == 0 && board.pending_answers.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== console_line_editor.f =====
+incdir+rtl
rtl/cle_pkg.sv
rtl/cle_ram.sv
rtl/cle_fifo.sv
rtl/cle_front.sv
rtl/cle_back.sv
rtl/console_line_editor.sv
rtl/cle_checker.sv
sim/testbench.sv
